@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the deque RTL modules.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

@@ hw/rtl/dqs_pkg.sv @@
// Shared types and codes for the deque with position search.
// No dependencies; imported by the controller, the datapath and the top level.
package dqs_pkg;

   // Default number of entries.
   localparam int DQS_DEPTH_DEFAULT = 16;

   // Fixed field widths.
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int OCC_W    = 5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DROP_BACK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // Controller states.
   typedef enum logic [1:0] {
      DQS_IDLE,
      DQS_SEARCH,
      DQS_RESP
   } dqs_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // take the request ports and apply the command
      logic step;   // advance the search walk by one entry
   } dqs_ctl_type;

   // Datapath to controller status.
   typedef struct packed {
      logic need_search;   // request on the ports is a find on a non-empty store
      logic search_done;   // current compare hit or was the last held entry
   } dqs_sts_type;

endpackage

@@ hw/rtl/dqs_ctrl.sv @@
// Controller state machine for the deque: accepts requests, runs find walks.
// Depends on dqs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dqs_ctrl
   import dqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   output dqs_ctl_type ctl,
   input  dqs_sts_type sts
);

   dqs_state_type state_ff;
   dqs_state_type state_in;

   // Hold the state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DQS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Choose the next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DQS_IDLE, DQS_RESP: begin
            if (start) begin
               state_in = sts.need_search ? DQS_SEARCH : DQS_RESP;
            end else begin
               state_in = DQS_IDLE;
            end
         end
         DQS_SEARCH: begin
            if (sts.search_done) begin
               state_in = DQS_RESP;
            end
         end
         default: state_in = DQS_IDLE;
      endcase
   end

   // Drive handshake and datapath commands.
   always_comb begin
      busy       = 1'b0;
      rsp_strobe = 1'b0;
      ctl.load   = 1'b0;
      ctl.step   = 1'b0;
      case (state_ff)
         DQS_IDLE: begin
            ctl.load = start;
         end
         DQS_SEARCH: begin
            busy     = 1'b1;
            ctl.step = 1'b1;
         end
         DQS_RESP: begin
            rsp_strobe = 1'b1;
            ctl.load   = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   `ASSERT_CLK_RST(a_idle_stays, clock, reset,
      (state_ff == DQS_IDLE && !start) |=> (state_ff == DQS_IDLE))
   `ASSERT_CLK_RST(a_search_ends, clock, reset,
      (state_ff == DQS_SEARCH && sts.search_done) |=> rsp_strobe)
   `ASSERT_CLK_RST(a_strobe_after_work, clock, reset,
      rsp_strobe |-> ($past(ctl.load) || $past(ctl.step)))

endmodule

@@ hw/rtl/dqs_dp.sv @@
// Datapath for the deque: entry memory, ring pointers, search walk, result.
// Depends on dqs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dqs_dp
   import dqs_pkg::*;
#(
   parameter int DEPTH = DQS_DEPTH_DEFAULT
)(
   input  logic                       clock,
   input  logic                       reset,
   input  dqs_ctl_type                ctl,
   output dqs_sts_type                sts,
   input  logic        [CMD_W-1:0]    req_cmd,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [POS_W-1:0]    rsp_position,
   output logic        [OCC_W-1:0]    rsp_occupancy
);

   localparam int IDXW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int SUMW = CNTW + 1;

   // Entry storage: one write port, one registered read port.
   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [IDXW-1:0]     front_ff, front_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic [CNTW-1:0]     rd_idx_ff, rd_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [CNTW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic            wr_en;
   logic [IDXW-1:0] wr_addr;
   logic            rd_en;
   logic [IDXW-1:0] rd_addr;
   logic            full;
   logic            empty;
   logic [IDXW-1:0] front_dec;
   logic            hit;
   logic            last;

   // Ring slot of the entry that sits offset places behind the front.
   function automatic logic [IDXW-1:0] ring_slot(input logic [IDXW-1:0] front,
                                                 input logic [CNTW-1:0] offset);
      logic [SUMW-1:0] sum;
      sum = SUMW'(front) + SUMW'(offset);
      if (sum >= SUMW'(DEPTH)) begin
         sum = sum - SUMW'(DEPTH);
      end
      return sum[IDXW-1:0];
   endfunction

   assign full      = (count_ff == CNTW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? IDXW'(DEPTH - 1) : front_ff - IDXW'(1);

   // Compare the entry read last cycle against the key.
   assign hit  = cmp_vld_ff && (rd_data_ff == key_ff);
   assign last = cmp_vld_ff && (cmp_idx_ff == count_ff - CNTW'(1));

   assign sts.need_search = (req_cmd == CMD_FIND) && !empty;
   assign sts.search_done = hit || last;

   // Issue the next search read while held entries remain.
   assign rd_en   = ctl.step && (rd_idx_ff < count_ff);
   assign rd_addr = ring_slot(front_ff, rd_idx_ff);

   // Apply a command, or advance the search.
   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      status_in  = status_ff;
      pos_in     = pos_ff;
      wr_en      = 1'b0;
      wr_addr    = ring_slot(front_ff, count_ff);
      if (ctl.load) begin
         status_in = ST_OK;
         pos_in    = '0;
         case (req_cmd)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  front_in = front_dec;
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  count_in = count_ff + CNTW'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNTW'(1);
               end
            end
            CMD_DROP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  front_in = ring_slot(front_ff, CNTW'(1));
                  count_in = count_ff - CNTW'(1);
               end
            end
            CMD_DROP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - CNTW'(1);
               end
            end
            CMD_FIND: begin
               status_in = ST_NOT_FOUND;
               key_in    = req_value;
               rd_idx_in = '0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end else if (ctl.step) begin
         cmp_vld_in = rd_en;
         cmp_idx_in = rd_idx_ff;
         if (rd_en) begin
            rd_idx_in = rd_idx_ff + CNTW'(1);
         end
         if (hit) begin
            status_in = ST_OK;
            pos_in    = POS_W'(cmp_idx_ff);
         end
      end
   end

   // Hold control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff   <= '0;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         front_ff   <= front_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // Hold payload.
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
   end

   // Write an entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= req_value;
      end
   end

   // Read an entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_position  = pos_ff;
   assign rsp_occupancy = OCC_W'(count_ff);

   `ASSERT_CLK_RST(a_count_bound, clock, reset, count_ff <= CNTW'(DEPTH))
   `ASSERT_CLK_RST(a_count_only_on_load, clock, reset,
      !ctl.load |=> $stable(count_ff))
   `ASSERT_CLK_RST(a_compare_held, clock, reset,
      cmp_vld_ff |-> (cmp_idx_ff < count_ff))

endmodule

@@ hw/rtl/deque_with_position_search.sv @@
// Top level of the bounded deque with position search.
// Depends on dqs_pkg, dqs_ctrl and dqs_dp.
//
// Channel   Ports                                         Transfer
// request   start, busy, req_cmd, req_value               start && !busy at clock edge
// response  rsp_strobe, rsp_status, rsp_position,         rsp_strobe high for one cycle
//           rsp_occupancy
//
// Push and drop: the result strobes in the cycle after the transfer,
// and a new request is taken in that same cycle.
// Find walks the held entries one per cycle through the single read port of the
// entry memory; it keeps busy high during the walk, then strobes the result.
// Reset clears the pointers and the occupancy; no clearing pass of the memory.
// The receiver cannot stall: every result is presented for exactly one cycle.
module deque_with_position_search
   import dqs_pkg::*;
#(
   parameter int DEPTH = DQS_DEPTH_DEFAULT
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic        [CMD_W-1:0]    req_cmd,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_strobe,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic        [POS_W-1:0]    rsp_position,
   output logic        [OCC_W-1:0]    rsp_occupancy
);

   dqs_ctl_type ctl;
   dqs_sts_type sts;

   // Sequence requests and search walks.
   dqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctl        (ctl),
      .sts        (sts)
   );

   // Store entries and build results.
   dqs_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule
